// ----- rtl/pasr_pkg.sv -----
// Shared types and constants of the priority arbiter with starvation round.
package pasr_pkg;

   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 256;
   localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QID_W       = 3;
   localparam int TICK_W      = 16;
   localparam int MASK_W      = 8;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 3;
   // Result queue depth; must be a power of two so the pointers wrap freely.
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_SERVE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      REG_STARVATION_TICKS   = 1'b0,
      REG_TIME_CRITICAL_MASK = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic             grant_valid;
      logic [QID_W-1:0] grant_queue;
      logic             starvation_round;
      logic             push_dropped;
      logic             last;
   } result_type;

   // Words produced by one accepted request: zero, one or two.
   typedef struct packed {
      logic [1:0] num;
      result_type word0;
      result_type word1;
   } result_write_type;

endpackage

// ----- rtl/priority_arbiter_with_starvation_round_core.sv -----
// Top level of the fixed-priority arbiter with starvation round.
//
// One request (push, serve or tick) is taken every clock cycle while req_ready
// is high: the occupancy and tick counters are updated in the cycle of
// acceptance and the result words go into a four-word result queue. A push
// and a normal serve each yield one word, a tick or an unknown action none,
// and a starvation-round serve yields two words, so a run of starvation
// serves is held back by the single-word output port. req_ready drops only
// while fewer than two result slots are free. The result words are written
// to the result queue and reach rsp_ in order, behind any earlier words.
module priority_arbiter_with_starvation_round_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [pasr_pkg::QID_W-1:0]      req_queue_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_grant_valid,
   output logic [pasr_pkg::QID_W-1:0]      rsp_grant_queue,
   output logic                            rsp_starvation_round,
   output logic                            rsp_push_dropped,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pasr_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [pasr_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [pasr_pkg::DATA_W-1:0]     csr_prdata,
   output logic                            csr_pready
);

   logic [pasr_pkg::TICK_W-1:0] starvation_ticks;
   logic [pasr_pkg::MASK_W-1:0] time_critical_mask;
   pasr_pkg::result_write_type  wr;
   pasr_pkg::result_type        head;
   logic                        room;

   assign req_ready = room;

   pasr_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .starvation_ticks   (starvation_ticks),
      .time_critical_mask (time_critical_mask)
   );

   pasr_core u_core (
      .clock              (clock),
      .reset              (reset),
      .accept             (req_valid & room),
      .action             (req_action),
      .queue_id           (req_queue_id),
      .starvation_ticks   (starvation_ticks),
      .time_critical_mask (time_critical_mask),
      .wr                 (wr)
   );

   pasr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (head)
   );

   assign rsp_grant_valid      = head.grant_valid;
   assign rsp_grant_queue      = head.grant_queue;
   assign rsp_starvation_round = head.starvation_round;
   assign rsp_push_dropped     = head.push_dropped;
   assign rsp_last             = head.last;

endmodule

// ----- rtl/pasr_csr.sv -----
// Configuration registers: starvation limit and time-critical mask.
module pasr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pasr_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [pasr_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [pasr_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output logic [pasr_pkg::TICK_W-1:0]   starvation_ticks,
   output logic [pasr_pkg::MASK_W-1:0]   time_critical_mask
);

   logic [pasr_pkg::TICK_W-1:0] starvation_ff, starvation_in;
   logic [pasr_pkg::MASK_W-1:0] mask_ff, mask_in;
   pasr_pkg::reg_index_type     index;
   logic                        write_en;

   assign index      = pasr_pkg::reg_index_type'(csr_paddr[2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      starvation_in = starvation_ff;
      mask_in       = mask_ff;
      csr_prdata    = '0;
      unique case (index)
         pasr_pkg::REG_STARVATION_TICKS: begin
            if (write_en) starvation_in = csr_pwdata[pasr_pkg::TICK_W-1:0];
            csr_prdata = pasr_pkg::DATA_W'(starvation_ff);
         end
         pasr_pkg::REG_TIME_CRITICAL_MASK: begin
            if (write_en) mask_in = csr_pwdata[pasr_pkg::MASK_W-1:0];
            csr_prdata = pasr_pkg::DATA_W'(mask_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         starvation_ff <= pasr_pkg::TICK_W'(30);
         mask_ff       <= '0;
      end else begin
         starvation_ff <= starvation_in;
         mask_ff       <= mask_in;
      end
   end

   assign starvation_ticks   = starvation_ff;
   assign time_critical_mask = mask_ff;

endmodule

// ----- rtl/pasr_core.sv -----
// Occupancy counters, tick counter and the grant logic for one request.
module pasr_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        action,
   input  logic [pasr_pkg::QID_W-1:0]        queue_id,
   input  logic [pasr_pkg::TICK_W-1:0]       starvation_ticks,
   input  logic [pasr_pkg::MASK_W-1:0]       time_critical_mask,
   output pasr_pkg::result_write_type        wr
);

   localparam int NQ = pasr_pkg::NUM_QUEUES;

   logic [pasr_pkg::CNT_W-1:0]  count_ff [NQ];
   logic [pasr_pkg::CNT_W-1:0]  count_in [NQ];
   logic [pasr_pkg::TICK_W-1:0] elapsed_ff, elapsed_in;

   pasr_pkg::action_type        act;
   logic [NQ-1:0]               nonempty, critical, after_first, push_hit;
   logic                        full_hit, dropped, starve;
   logic                        f_norm, f_crit, f_rev;
   logic [pasr_pkg::QIDX_W-1:0] q_norm, q_crit, q_rev;
   logic [1:0]                  dec [NQ];

   assign act      = pasr_pkg::action_type'(action);
   assign critical = NQ'(time_critical_mask);
   assign starve   = elapsed_ff >= starvation_ticks;

   always_comb begin
      full_hit = 1'b0;
      for (int q = 0; q < NQ; q++) begin
         nonempty[q] = count_ff[q] != '0;
         push_hit[q] = 32'(queue_id) == q;
         if (push_hit[q] && count_ff[q] >= pasr_pkg::CNT_W'(pasr_pkg::QUEUE_DEPTH)) begin
            full_hit = 1'b1;
         end
      end
      // A push to a queue index that does not exist matches no counter.
      dropped = full_hit | ~(|push_hit);
   end

   // Highest-priority non-empty queue, and the same among time-critical ones.
   always_comb begin
      q_norm = '0;
      q_crit = '0;
      for (int q = NQ - 1; q >= 0; q--) begin
         if (nonempty[q]) q_norm = pasr_pkg::QIDX_W'(q);
         if (nonempty[q] && critical[q]) q_crit = pasr_pkg::QIDX_W'(q);
      end
      f_norm = |nonempty;
      f_crit = |(nonempty & critical);
   end

   // The reverse scan sees the occupancy left by the time-critical grant.
   always_comb begin
      for (int q = 0; q < NQ; q++) begin
         after_first[q] = nonempty[q] &
            ~(f_crit && (32'(q_crit) == q) && (count_ff[q] == pasr_pkg::CNT_W'(1)));
      end
      q_rev = '0;
      for (int q = 0; q < NQ; q++) begin
         if (after_first[q]) q_rev = pasr_pkg::QIDX_W'(q);
      end
      f_rev = |after_first;
   end

   always_comb begin
      wr         = '0;
      elapsed_in = elapsed_ff;
      for (int q = 0; q < NQ; q++) begin
         dec[q]      = 2'd0;
         count_in[q] = count_ff[q];
      end
      unique case (act)
         pasr_pkg::ACT_PUSH: begin
            wr.num               = 2'd1;
            wr.word0.push_dropped = dropped;
            wr.word0.last        = 1'b1;
            for (int q = 0; q < NQ; q++) begin
               if (push_hit[q] && !dropped) count_in[q] = count_ff[q] + 1'b1;
            end
         end
         pasr_pkg::ACT_SERVE: begin
            if (!starve) begin
               wr.num               = 2'd1;
               wr.word0.grant_valid = f_norm;
               wr.word0.grant_queue = f_norm ? pasr_pkg::QID_W'(q_norm) : '0;
               wr.word0.last        = 1'b1;
               for (int q = 0; q < NQ; q++) begin
                  if (f_norm && 32'(q_norm) == q) dec[q] = 2'd1;
               end
            end else begin
               wr.num                    = 2'd2;
               wr.word0.grant_valid      = f_crit;
               wr.word0.grant_queue      = f_crit ? pasr_pkg::QID_W'(q_crit) : '0;
               wr.word0.starvation_round = 1'b1;
               wr.word1.grant_valid      = f_rev;
               wr.word1.grant_queue      = f_rev ? pasr_pkg::QID_W'(q_rev) : '0;
               wr.word1.starvation_round = 1'b1;
               wr.word1.last             = 1'b1;
               elapsed_in                = '0;
               for (int q = 0; q < NQ; q++) begin
                  dec[q] = 2'(f_crit && 32'(q_crit) == q) + 2'(f_rev && 32'(q_rev) == q);
               end
            end
            for (int q = 0; q < NQ; q++) begin
               count_in[q] = count_ff[q] - pasr_pkg::CNT_W'(dec[q]);
            end
         end
         pasr_pkg::ACT_TICK: begin
            if (elapsed_ff != '1) elapsed_in = elapsed_ff + 1'b1;
         end
         pasr_pkg::ACT_NONE: begin
         end
      endcase
      if (!accept) wr.num = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         for (int q = 0; q < NQ; q++) count_ff[q] <= '0;
      end else if (accept) begin
         elapsed_ff <= elapsed_in;
         for (int q = 0; q < NQ; q++) count_ff[q] <= count_in[q];
      end
   end

endmodule

// ----- rtl/pasr_rsp_fifo.sv -----
// Small result queue that takes up to two words per cycle and gives one while out_ready is high.
module pasr_rsp_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  pasr_pkg::result_write_type wr,
   output logic                       room,
   output logic                       out_valid,
   input  logic                       out_ready,
   output pasr_pkg::result_type       out_word
);

   pasr_pkg::result_type           entry_ff [pasr_pkg::RSP_DEPTH];
   logic [pasr_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pasr_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pasr_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic                           pop;

   assign out_valid = count_ff != '0;
   assign pop       = out_valid & out_ready;
   assign out_word  = entry_ff[rd_ptr_ff];
   // Room for a two-word result is kept free before a request is taken.
   assign room      = count_ff <= pasr_pkg::RSP_CNT_W'(pasr_pkg::RSP_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pasr_pkg::RSP_PTR_W'(wr.num);
      rd_ptr_in = rd_ptr_ff + pasr_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + pasr_pkg::RSP_CNT_W'(wr.num) - pasr_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.num != 2'd0) entry_ff[wr_ptr_ff] <= wr.word0;
      if (wr.num == 2'd2) entry_ff[wr_ptr_ff + 1'b1] <= wr.word1;
   end

endmodule
